// ===== hdl/owbm_pkg.sv =====
package owbm_pkg;

    // Timer and presence settings
    localparam int TICK_WIDTH       = 16;
    localparam int PRESENCE_SAMPLES = 10;

    // Timing registers are 16 bits; lengths derived from them fit in 17 bits
    localparam int CFG_W  = 16;
    localparam int LEN_W  = CFG_W + 1;
    localparam int CMP_W  = (TICK_WIDTH + 1 > LEN_W) ? TICK_WIDTH + 1 : LEN_W;
    localparam int SC_W   = 4;
    localparam int IDX_W  = 2;

    // Request queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_RESET_TICKS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SLOT_TICKS   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SAMPLE_TICKS = 2'd2;
    localparam logic [IDX_W-1:0] CFG_INIT_TICKS   = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] RESET_TICKS_INIT  = 16'd1200;
    localparam logic [CFG_W-1:0] SLOT_TICKS_INIT   = 16'd200;
    localparam logic [CFG_W-1:0] SAMPLE_TICKS_INIT = 16'd10;
    localparam logic [CFG_W-1:0] INIT_TICKS_INIT   = 16'd25;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_RST_LOW    = 4'd1,
        PH_RST_GAP    = 4'd2,
        PH_RST_SAMPLE = 4'd3,
        PH_RST_TAIL   = 4'd4,
        PH_W_GAP      = 4'd5,
        PH_W_LOW      = 4'd6,
        PH_W_REL      = 4'd7,
        PH_W_TAIL     = 4'd8,
        PH_R_LOW      = 4'd9,
        PH_R_SAMPLE   = 4'd10,
        PH_R_REST     = 4'd11,
        PH_R_TAIL     = 4'd12
    } phase_t;

    // One classified tick request
    typedef struct packed {
        cmd_t       cmd;
        phase_t     first_phase;
        logic [7:0] first_byte;
        logic       line;
    } req_t;

endpackage

// ===== hdl/one_wire_bus_master.sv =====
// Timed 1-Wire bus master. Every input request is one tick of the bus timer:
// it carries the sampled line level and, while the master is idle, may start
// a bus reset with presence detect, a byte write or a byte read (LSB first).
// Every request yields exactly one result holding the line drive for that
// tick plus busy, done, presence, read data and a rejected flag for commands
// that arrive while a sequence runs.
// Channels: in_valid/in_ready and out_valid/out_ready. Timing registers are
// written through cfg_write/cfg_index/cfg_data; the user must write them only
// while the master is idle, as the block itself does not enforce this.
// A request is first held in a queue slot; the sequencer then writes its
// result to the output register. One request per cycle while the receiver
// takes results; the two-entry request queue and the output register let the
// front keep accepting while a result waits.
// When the receiver stalls, the result holds, the sequencer stops, and the
// queue fills; in_ready drops once both queue entries are taken.
// Reset: sequencer idle, queue empty, no result pending, timing registers at
// 1200/200/10/25 ticks.
module one_wire_bus_master (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [owbm_pkg::IDX_W-1:0] cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [7:0]                 data_byte,
    input  logic                       line_level,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       presence,
    output logic [7:0]                 read_data,
    output logic                       rejected
);
    import owbm_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_req;

    // Front: classify requests and queue them
    owbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_byte  (data_byte),
        .line_level (line_level),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop)
    );

    // Back: phase sequencer and output register
    owbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_low  (drive_low),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .presence   (presence),
        .read_data  (read_data),
        .rejected   (rejected)
    );

`ifndef ASSERT_OFF
    // The line is only pulled low inside a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_low |-> busy_res)
        else $error("drive_low outside a sequence");

    // Done and rejected only while a sequence runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_res || rejected) |-> busy_res)
        else $error("done or rejected while idle");

    // Presence and read data are only reported on the finishing tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (presence || read_data != 8'd0) |-> done_res)
        else $error("status reported before sequence end");

    // A result cannot appear without a request taken before it
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(u_front.q_valid))
        else $error("result without queued request");
`endif

endmodule

// ===== hdl/owbm_front.sv =====
module owbm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    command,
    input  logic [7:0]    data_byte,
    input  logic          line_level,
    output logic          q_valid,
    output owbm_pkg::req_t q_req,
    input  logic          q_pop
);
    import owbm_pkg::*;

    req_t                req_in;
    req_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push;

    // Classify the incoming request: start phase and preloaded shift byte
    always_comb
    begin
        req_in.cmd        = cmd_t'(command);
        req_in.line       = line_level;
        req_in.first_byte = 8'd0;
        case (cmd_t'(command))
            CMD_RESET: req_in.first_phase = PH_RST_LOW;
            CMD_WRITE:
            begin
                req_in.first_phase = PH_W_GAP;
                req_in.first_byte  = data_byte;
            end
            CMD_READ:  req_in.first_phase = PH_R_LOW;
            default:   req_in.first_phase = PH_IDLE;
        endcase
    end

    assign in_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_req    = mem[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= req_in;
    end

endmodule

// ===== hdl/owbm_back.sv =====
module owbm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [owbm_pkg::IDX_W-1:0] cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0] cfg_data,
    input  logic                      q_valid,
    input  owbm_pkg::req_t            q_req,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      drive_low,
    output logic                      busy_res,
    output logic                      done_res,
    output logic                      presence,
    output logic [7:0]                read_data,
    output logic                      rejected
);
    import owbm_pkg::*;

    // Timing registers
    logic [CFG_W-1:0] reset_ticks_reg, slot_ticks_reg, sample_ticks_reg, init_ticks_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [SC_W-1:0]       sc_reg, sc_next;
    logic                  found_reg, found_next;
    cmd_t                  oper_reg, oper_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic       drive_reg, busy_reg, done_reg, pres_reg, rej_reg;
    logic [7:0] rdata_reg;
    logic       drive_c, busy_c, done_c, pres_c, rej_c;
    logic [7:0] rdata_c;

    // Working values after a possible command start
    logic                  take, start;
    phase_t                cur_phase;
    logic [TICK_WIDTH-1:0] cur_tick;
    logic [2:0]            cur_bit;
    logic [7:0]            cur_shift;
    logic [SC_W-1:0]       cur_sc;
    logic                  cur_found;
    cmd_t                  cur_oper;

    // Phase length datapath
    logic [CFG_W-1:0] reset1, slot1, smp1, init1, wlow;
    logic [LEN_W-1:0] w_rel, r_sum, r_rest, len;
    logic [CMP_W-1:0] len_cap, tick_plus;
    logic [SC_W-1:0]  sc_plus;

    assign take  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = take;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_ticks_reg  <= RESET_TICKS_INIT;
            slot_ticks_reg   <= SLOT_TICKS_INIT;
            sample_ticks_reg <= SAMPLE_TICKS_INIT;
            init_ticks_reg   <= INIT_TICKS_INIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RESET_TICKS:  reset_ticks_reg  <= cfg_data;
                CFG_SLOT_TICKS:   slot_ticks_reg   <= cfg_data;
                CFG_SAMPLE_TICKS: sample_ticks_reg <= cfg_data;
                CFG_INIT_TICKS:   init_ticks_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Command start and rejection
    always_comb
    begin
        start     = (phase_reg == PH_IDLE) && (q_req.cmd != CMD_TICK);
        rej_c     = (phase_reg != PH_IDLE) && (q_req.cmd != CMD_TICK);
        cur_phase = start ? q_req.first_phase : phase_reg;
        cur_tick  = start ? '0 : tick_reg;
        cur_bit   = start ? 3'd0 : bit_reg;
        cur_shift = start ? q_req.first_byte : shift_reg;
        cur_sc    = start ? '0 : sc_reg;
        cur_found = start ? 1'b0 : found_reg;
        cur_oper  = start ? q_req.cmd : oper_reg;
    end

    // Phase lengths; a zero register counts as one tick
    always_comb
    begin
        reset1 = (reset_ticks_reg == '0)  ? CFG_W'(1) : reset_ticks_reg;
        slot1  = (slot_ticks_reg == '0)   ? CFG_W'(1) : slot_ticks_reg;
        smp1   = (sample_ticks_reg == '0) ? CFG_W'(1) : sample_ticks_reg;
        init1  = (init_ticks_reg == '0)   ? CFG_W'(1) : init_ticks_reg;
        wlow   = cur_shift[cur_bit] ? init1 : slot1;
        w_rel  = (slot1 > wlow) ? LEN_W'(slot1 - wlow) : '0;
        r_sum  = LEN_W'(init1) + LEN_W'(smp1);
        r_rest = (LEN_W'(slot1) > r_sum) ? LEN_W'(slot1) - r_sum : '0;
        case (cur_phase)
            PH_RST_LOW:    len = LEN_W'(reset1);
            PH_RST_GAP:    len = LEN_W'(init1);
            PH_RST_SAMPLE: len = LEN_W'(smp1);
            PH_RST_TAIL:   len = LEN_W'(slot1);
            PH_W_GAP:      len = LEN_W'(init1);
            PH_W_LOW:      len = LEN_W'(wlow);
            PH_W_REL:      len = w_rel;
            PH_W_TAIL:     len = LEN_W'(init1);
            PH_R_LOW:      len = LEN_W'(init1);
            PH_R_SAMPLE:   len = LEN_W'(smp1);
            PH_R_REST:     len = r_rest;
            PH_R_TAIL:     len = LEN_W'(init1);
            default:       len = LEN_W'(1);
        endcase
        // Long phases saturate at the timer range
        len_cap = (CMP_W'(len) > (CMP_W'(1) << TICK_WIDTH)) ?
                  (CMP_W'(1) << TICK_WIDTH) : CMP_W'(len);
        tick_plus = CMP_W'(cur_tick) + CMP_W'(1);
        sc_plus   = cur_sc + 1'b1;
    end

    // Phase sequencer: next state and result of this tick
    always_comb
    begin
        phase_next = cur_phase;
        tick_next  = cur_tick;
        bit_next   = cur_bit;
        shift_next = cur_shift;
        sc_next    = cur_sc;
        found_next = cur_found;
        oper_next  = cur_oper;
        drive_c    = 1'b0;
        busy_c     = 1'b0;
        done_c     = 1'b0;
        pres_c     = 1'b0;
        rdata_c    = 8'd0;
        if (cur_phase != PH_IDLE)
        begin
            busy_c  = 1'b1;
            drive_c = (cur_phase == PH_RST_LOW) || (cur_phase == PH_W_LOW) ||
                      (cur_phase == PH_R_LOW);
            if (tick_plus >= len_cap)
            begin
                tick_next = '0;
                case (cur_phase)
                    PH_RST_LOW:  phase_next = PH_RST_GAP;
                    PH_RST_GAP:  phase_next = PH_RST_SAMPLE;
                    PH_RST_SAMPLE:
                    begin
                        if (!q_req.line)
                            found_next = 1'b1;
                        sc_next    = sc_plus;
                        phase_next = (sc_plus >= SC_W'(PRESENCE_SAMPLES)) ?
                                     PH_RST_TAIL : PH_RST_SAMPLE;
                    end
                    PH_RST_TAIL: phase_next = PH_IDLE;
                    PH_W_GAP:    phase_next = PH_W_LOW;
                    PH_W_LOW:    phase_next = (w_rel != '0) ? PH_W_REL : PH_W_TAIL;
                    PH_W_REL:    phase_next = PH_W_TAIL;
                    PH_R_LOW:    phase_next = PH_R_SAMPLE;
                    PH_R_SAMPLE:
                    begin
                        shift_next[cur_bit] = cur_shift[cur_bit] | q_req.line;
                        phase_next = (r_rest != '0) ? PH_R_REST : PH_R_TAIL;
                    end
                    PH_R_REST:   phase_next = PH_R_TAIL;
                    PH_W_TAIL, PH_R_TAIL:
                    begin
                        if (cur_bit == 3'd7)
                            phase_next = PH_IDLE;
                        else
                        begin
                            bit_next   = cur_bit + 3'd1;
                            phase_next = (cur_phase == PH_W_TAIL) ? PH_W_GAP : PH_R_LOW;
                        end
                    end
                    default:     phase_next = PH_IDLE;
                endcase
                if (phase_next == PH_IDLE)
                begin
                    done_c = 1'b1;
                    if (cur_oper == CMD_RESET)
                        pres_c = found_next;
                    if (cur_oper == CMD_READ)
                        rdata_c = shift_next;
                end
            end
            else
            begin
                tick_next = tick_plus[TICK_WIDTH-1:0];
            end
        end
    end

    // Sequencer state advances once per taken request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            sc_reg    <= '0;
            found_reg <= 1'b0;
            oper_reg  <= CMD_TICK;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            sc_reg    <= sc_next;
            found_reg <= found_next;
            oper_reg  <= oper_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg <= drive_c;
            busy_reg  <= busy_c;
            done_reg  <= done_c;
            pres_reg  <= pres_c;
            rdata_reg <= rdata_c;
            rej_reg   <= rej_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_low = drive_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign presence  = pres_reg;
    assign read_data = rdata_reg;
    assign rejected  = rej_reg;

endmodule

// ===== tb/owbm_checker.sv =====
`timescale 1ns / 100ps

module owbm_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [owbm_pkg::IDX_W-1:0] cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [7:0]                 data_byte,
    input  logic                       line_level,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       drive_low,
    input  logic                       busy_res,
    input  logic                       done_res,
    input  logic                       presence,
    input  logic [7:0]                 read_data,
    input  logic                       rejected,
    output int                         fail_count,
    output int                         results_left,
    output logic                       seq_busy
);
    import owbm_pkg::*;

    localparam longint unsigned TICK_CAP = 64'd1 << TICK_WIDTH;

    // What the bus master should report for one tick
    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic       pres;
        logic [7:0] rdata;
        logic       rej;
    } tick_result_t;

    // Timing registers as last written
    logic [CFG_W-1:0] t_reset  = RESET_TICKS_INIT;
    logic [CFG_W-1:0] t_slot   = SLOT_TICKS_INIT;
    logic [CFG_W-1:0] t_sample = SAMPLE_TICKS_INIT;
    logic [CFG_W-1:0] t_init   = INIT_TICKS_INIT;

    // Sequencer state
    phase_t            ph           = PH_IDLE;
    longint unsigned   ticks        = 0;
    logic [2:0]        bit_no       = '0;
    logic [7:0]        shreg        = '0;
    logic [SC_W-1:0]   samples_seen = '0;
    logic              dev_found    = 1'b0;
    cmd_t              op_kind      = CMD_TICK;

    tick_result_t      results_due[$];
    int                mismatches   = 0;
    int                due_count    = 0;
    logic              busy_seen    = 1'b0;

    assign fail_count   = mismatches;
    assign results_left = due_count;
    assign seq_busy     = busy_seen;

    // A zero register counts as one tick
    function automatic longint unsigned floor_one(logic [CFG_W-1:0] v);
        return (v == '0) ? 64'd1 : longint'(v);
    endfunction

    function automatic longint unsigned phase_ticks(phase_t p);
        longint unsigned slot;
        longint unsigned ini;
        longint unsigned smp;
        longint unsigned low_w;
        longint unsigned n;
        slot  = floor_one(t_slot);
        ini   = floor_one(t_init);
        smp   = floor_one(t_sample);
        low_w = shreg[bit_no] ? ini : slot;
        case (p)
            PH_RST_LOW:    n = floor_one(t_reset);
            PH_RST_GAP:    n = ini;
            PH_RST_SAMPLE: n = smp;
            PH_RST_TAIL:   n = slot;
            PH_W_GAP:      n = ini;
            PH_W_LOW:      n = low_w;
            PH_W_REL:      n = (slot > low_w) ? slot - low_w : 0;
            PH_W_TAIL:     n = ini;
            PH_R_LOW:      n = ini;
            PH_R_SAMPLE:   n = smp;
            PH_R_REST:     n = (slot > ini + smp) ? slot - ini - smp : 0;
            PH_R_TAIL:     n = ini;
            default:       n = 1;
        endcase
        return (n > TICK_CAP) ? TICK_CAP : n;
    endfunction

    // Phase that follows p; samples the line where the phase calls for it
    function automatic phase_t phase_after(phase_t p, logic ln);
        case (p)
            PH_RST_LOW: return PH_RST_GAP;
            PH_RST_GAP: return PH_RST_SAMPLE;
            PH_RST_SAMPLE:
            begin
                if (!ln)
                    dev_found = 1'b1;
                samples_seen = samples_seen + 1'b1;
                return (samples_seen >= PRESENCE_SAMPLES) ? PH_RST_TAIL : PH_RST_SAMPLE;
            end
            PH_RST_TAIL: return PH_IDLE;
            PH_W_GAP:    return PH_W_LOW;
            PH_W_LOW:    return (phase_ticks(PH_W_REL) > 0) ? PH_W_REL : PH_W_TAIL;
            PH_W_REL:    return PH_W_TAIL;
            PH_R_LOW:    return PH_R_SAMPLE;
            PH_R_SAMPLE:
            begin
                shreg[bit_no] = shreg[bit_no] | ln;
                return (phase_ticks(PH_R_REST) > 0) ? PH_R_REST : PH_R_TAIL;
            end
            PH_R_REST:   return PH_R_TAIL;
            PH_W_TAIL, PH_R_TAIL:
            begin
                if (bit_no == 3'd7)
                    return PH_IDLE;
                bit_no = bit_no + 1'b1;
                return (p == PH_W_TAIL) ? PH_W_GAP : PH_R_LOW;
            end
            default:     return PH_IDLE;
        endcase
    endfunction

    // Advance the bus timer by one tick request
    function automatic tick_result_t step_bus(cmd_t c, logic [7:0] d, logic ln);
        tick_result_t    r;
        longint unsigned n;
        r = '0;
        if (ph != PH_IDLE)
            r.rej = (c != CMD_TICK);
        else if (c != CMD_TICK)
        begin
            op_kind      = c;
            ticks        = 0;
            bit_no       = '0;
            samples_seen = '0;
            dev_found    = 1'b0;
            shreg        = (c == CMD_WRITE) ? d : 8'h00;
            ph = (c == CMD_RESET) ? PH_RST_LOW : (c == CMD_WRITE) ? PH_W_GAP : PH_R_LOW;
        end

        if (ph != PH_IDLE)
        begin
            n       = phase_ticks(ph);
            r.busy  = 1'b1;
            r.drive = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);
            if (ticks + 1 >= n)
            begin
                ticks = 0;
                ph    = phase_after(ph, ln);
                if (ph == PH_IDLE)
                begin
                    r.done = 1'b1;
                    if (op_kind == CMD_RESET)
                        r.pres = dev_found;
                    if (op_kind == CMD_READ)
                        r.rdata = shreg;
                end
            end
            else
                ticks = ticks + 1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result(input tick_result_t want);
        if (drive_low !== want.drive)
            report_mismatch("drive_low", int'(drive_low), int'(want.drive));
        if (busy_res !== want.busy)
            report_mismatch("busy_res", int'(busy_res), int'(want.busy));
        if (done_res !== want.done)
            report_mismatch("done_res", int'(done_res), int'(want.done));
        if (presence !== want.pres)
            report_mismatch("presence", int'(presence), int'(want.pres));
        if (read_data !== want.rdata)
            report_mismatch("read_data", int'(read_data), int'(want.rdata));
        if (rejected !== want.rej)
            report_mismatch("rejected", int'(rejected), int'(want.rej));
    endtask

    // Watch register writes, results and requests at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reset      = RESET_TICKS_INIT;
            t_slot       = SLOT_TICKS_INIT;
            t_sample     = SAMPLE_TICKS_INIT;
            t_init       = INIT_TICKS_INIT;
            ph           = PH_IDLE;
            ticks        = 0;
            bit_no       = '0;
            shreg        = '0;
            samples_seen = '0;
            dev_found    = 1'b0;
            op_kind      = CMD_TICK;
            results_due.delete();
            due_count    <= 0;
            busy_seen    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_RESET_TICKS:  t_reset  = cfg_data;
                    CFG_SLOT_TICKS:   t_slot   = cfg_data;
                    CFG_SAMPLE_TICKS: t_sample = cfg_data;
                    CFG_INIT_TICKS:   t_init   = cfg_data;
                    default:          ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result with no request waiting", 1, 0);
                else
                    check_result(results_due.pop_front());
            end

            if (in_valid && in_ready)
                results_due.push_back(step_bus(cmd_t'(command), data_byte, line_level));

            due_count <= results_due.size();
            busy_seen <= (ph != PH_IDLE);
        end
    end

endmodule

// ===== tb/tb_one_wire_bus_master.sv =====
`timescale 1ns / 100ps

module tb_one_wire_bus_master;

    import owbm_pkg::*;

    typedef enum int {
        LINE_HIGH,
        LINE_LOW,
        LINE_NOISE
    } line_mode_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_write  = 1'b0;
    logic [IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_ready;
    logic [1:0]       command    = CMD_TICK;
    logic [7:0]       data_byte  = '0;
    logic             line_level = 1'b1;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic             presence;
    logic [7:0]       read_data;
    logic             rejected;

    int               fail_count;
    int               results_left;
    logic             seq_busy;

    bit               gaps_on    = 1'b1;
    line_mode_t       line_mode  = LINE_NOISE;
    int               sent_total = 0;

    one_wire_bus_master u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_byte  (data_byte),
        .line_level (line_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_low  (drive_low),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .presence   (presence),
        .read_data  (read_data),
        .rejected   (rejected)
    );

    owbm_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .data_byte    (data_byte),
        .line_level   (line_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_low    (drive_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .presence     (presence),
        .read_data    (read_data),
        .rejected     (rejected),
        .fail_count   (fail_count),
        .results_left (results_left),
        .seq_busy     (seq_busy)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the bench hangs
    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic pick_line();
        case (line_mode)
            LINE_HIGH: return 1'b1;
            LINE_LOW:  return 1'b0;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // One tick request; returns at the edge that accepts it
    task automatic send_tick(input cmd_t c, input logic [7:0] d, input logic ln);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= c;
        data_byte  <= d;
        line_level <= ln;
        do
            @(posedge clk);
        while (!in_ready);
        sent_total++;
    endtask

    // Keep ticking until the running sequence has finished
    task automatic ride_out_sequence();
        do
            send_tick(CMD_TICK, 8'($urandom_range(0, 255)), pick_line());
        while (seq_busy);
    endtask

    // Stop requests and let every result drain before touching registers
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (results_left != 0 && waited < 2000);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_timing(input logic [CFG_W-1:0] rst_t, input logic [CFG_W-1:0] slot_t,
                               input logic [CFG_W-1:0] smp_t, input logic [CFG_W-1:0] init_t);
        cfg_write <= 1'b1;
        cfg_index <= CFG_RESET_TICKS;
        cfg_data  <= rst_t;
        @(posedge clk);
        cfg_index <= CFG_SLOT_TICKS;
        cfg_data  <= slot_t;
        @(posedge clk);
        cfg_index <= CFG_SAMPLE_TICKS;
        cfg_data  <= smp_t;
        @(posedge clk);
        cfg_index <= CFG_INIT_TICKS;
        cfg_data  <= init_t;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Receiver side: random stall before each result
    initial
    begin
        int stall;
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 7) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Stimulus
    initial
    begin
        int   batch;
        cmd_t c;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bus reset with the timing registers at their reset values; once the
        // low time is well under way, shorten it and the tail slot mid-sequence
        line_mode = LINE_NOISE;
        send_tick(CMD_RESET, 8'h00, 1'b0);
        for (int k = 0; k < 40; k++)
            send_tick(CMD_TICK, 8'($urandom_range(0, 255)), pick_line());
        settle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_RESET_TICKS;
        cfg_data  <= 16'd8;
        @(posedge clk);
        cfg_index <= CFG_SLOT_TICKS;
        cfg_data  <= 16'd3;
        @(posedge clk);
        cfg_write <= 1'b0;
        ride_out_sequence();
        settle();

        // Zero registers behave as one tick
        load_timing(16'd0, 16'd0, 16'd0, 16'd0);

        // Device pulls the line low in the presence window
        line_mode = LINE_LOW;
        send_tick(CMD_RESET, 8'h00, 1'b0);
        ride_out_sequence();

        // Nobody answers
        line_mode = LINE_HIGH;
        send_tick(CMD_RESET, 8'hFF, 1'b1);
        ride_out_sequence();

        // All-ones byte; commands arriving mid-byte get rejected
        send_tick(CMD_WRITE, 8'hFF, 1'b1);
        send_tick(CMD_READ, 8'h00, 1'b1);
        send_tick(CMD_RESET, 8'h5A, 1'b0);
        send_tick(CMD_WRITE, 8'h00, 1'b1);
        ride_out_sequence();

        send_tick(CMD_WRITE, 8'h00, 1'b0);
        ride_out_sequence();

        // Reads of an idle-high bus, a held-low bus, and noise
        send_tick(CMD_READ, 8'h00, 1'b1);
        ride_out_sequence();
        line_mode = LINE_LOW;
        send_tick(CMD_READ, 8'hFF, 1'b0);
        ride_out_sequence();
        line_mode = LINE_NOISE;
        send_tick(CMD_READ, 8'hA5, 1'b1);
        ride_out_sequence();
        settle();

        // Longer reset, slot and gap; run flat out with no stalls
        load_timing(16'd200, 16'd40, 16'd1, 16'd30);
        gaps_on   = 1'b0;
        line_mode = LINE_HIGH;
        send_tick(CMD_RESET, 8'h00, 1'b1);
        send_tick(CMD_WRITE, 8'hC3, 1'b1);
        ride_out_sequence();
        settle();

        // Random phases with short timing
        while (sent_total < 1450)
        begin
            load_timing(16'($urandom_range(0, 20)), 16'($urandom_range(0, 16)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(0, 4)));
            gaps_on = ($urandom_range(0, 3) != 0);
            batch   = $urandom_range(50, 150);
            for (int k = 0; k < batch; k++)
            begin
                if (k % 32 == 0)
                    line_mode = line_mode_t'($urandom_range(0, 2));
                if ($urandom_range(0, 7) == 0)
                    c = cmd_t'($urandom_range(1, 3));
                else
                    c = CMD_TICK;
                send_tick(c, 8'($urandom_range(0, 255)), pick_line());
            end
            ride_out_sequence();
            settle();
        end

        if (fail_count == 0 && results_left == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
